// ===== src/chlcd_pkg.sv =====
// package: request codes, bus constants and sequencer state type for the lcd text sequencer
`timescale 1ns / 1ps

package chlcd_pkg;

  // request codes carried on cmd
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_GOTO   = 3'd1;
  localparam logic [2:0] CMD_CHAR   = 3'd2;
  localparam logic [2:0] CMD_NUMBER = 3'd3;
  localparam logic [2:0] CMD_GLYPH  = 3'd4;

  // register select values
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // fixed bus bytes
  localparam logic [7:0] FUNC_SET_BYTE  = 8'b0011_1000;
  localparam logic [7:0] DISP_ON_BYTE   = 8'b0000_1100;
  localparam logic [7:0] CLEAR_BYTE     = 8'h01;
  localparam logic [7:0] WRAP_GOTO_BYTE = 8'hC0;
  localparam logic [7:0] WRAP_COLUMN    = 8'd16;
  localparam logic [7:0] ROW1_BASE      = 8'h40;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  // decimal conversion, glyph and init sizes
  localparam int NUM_BITS   = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_BITS   = 4 * NUM_DIGITS;
  localparam int GLYPH_ROWS = 8;
  localparam int INIT_WRITES = 3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_INIT,
    ST_GOTO,
    ST_DATA,
    ST_GHDR,
    ST_GROW
  } state_t;

  // command bytes of the init request, in order
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = FUNC_SET_BYTE;
      2'd1:    b = DISP_ON_BYTE;
      2'd2:    b = CLEAR_BYTE;
      default: b = CLEAR_BYTE;
    endcase
    return b;
  endfunction

endpackage

// ===== src/char_lcd_text_sequencer_unit.sv =====
// top level: turns lcd text requests into a stream of register-select and byte bus writes
`timescale 1ns / 1ps

// One request is taken on the in_ channel (in_valid high, in_stall low) and
// becomes a run of bus writes on the out_ channel, each a register select
// flag and a byte; out_last marks the final write of a request. Requests
// that produce nothing (unused codes, glyph slot above 7) are simply taken.
// in_stall stays high from the cycle after a request is taken until its last
// write has been loaded into the output register, so one request is in work
// at a time; a finished write waiting in the output register does not hold
// up the next request.
// Writes leave at one per cycle while out_stall is low: init makes 3
// writes, goto 1, char 1 or 2, glyph 11 or 12. A number request first runs
// a bit-serial binary to decimal conversion, one input bit per cycle, then
// drops leading zero digits one per cycle (up to 9), leaves that step, and
// then emits the goto and up to 10 digits, plus a goto to row 1 when the
// digits wrap.
// First write appears in the output register in the cycle after it is formed.
// While out_stall is high the output register holds its write and the
// sequencer waits. Synchronous reset clears the sequencer, the output valid
// and the cursor counter to zero.
module char_lcd_text_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [31:0] in_number,
  input  logic        in_row,
  input  logic [5:0]  in_column,
  input  logic [3:0]  in_glyph_index,
  input  logic [63:0] in_glyph_rows,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reg_select,
  output logic [7:0]  out_bus_byte,
  output logic        out_last
);

  localparam int BCDW = chlcd_pkg::BCD_BITS;

  chlcd_pkg::state_t state_r, state_nxt;

  // latched request
  logic [2:0]  cmd_r, cmd_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        row_r, row_nxt;
  logic [5:0]  col_r, col_nxt;
  logic [2:0]  gidx_r, gidx_nxt;
  logic [63:0] rows_r, rows_nxt;
  logic [31:0] num_r, num_nxt;
  logic [BCDW-1:0] bcd_r, bcd_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [7:0]  cursor_r, cursor_nxt;

  // output register
  logic        out_valid_r;
  logic        out_rs_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic        in_take;
  logic        can_emit;
  logic        emit;
  logic        emit_rs;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        wrap;
  logic [3:0]  top_digit;
  logic [BCDW-1:0] bcd_adj;

  assign in_stall  = (state_r != chlcd_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign can_emit  = !out_valid_r || !out_stall;
  assign wrap      = (cursor_r == chlcd_pkg::WRAP_COLUMN);
  assign top_digit = bcd_r[BCDW-1 -: 4];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chlcd_pkg::ST_IDLE: begin
        if (in_take) begin
          unique case (in_cmd)
            chlcd_pkg::CMD_INIT:   state_nxt = chlcd_pkg::ST_INIT;
            chlcd_pkg::CMD_GOTO:   state_nxt = chlcd_pkg::ST_GOTO;
            chlcd_pkg::CMD_CHAR:   state_nxt = chlcd_pkg::ST_DATA;
            chlcd_pkg::CMD_NUMBER: state_nxt = chlcd_pkg::ST_CONV;
            chlcd_pkg::CMD_GLYPH: begin
              if (!in_glyph_index[3]) state_nxt = chlcd_pkg::ST_GHDR;
            end
            default: state_nxt = chlcd_pkg::ST_IDLE;
          endcase
        end
      end
      chlcd_pkg::ST_CONV: begin
        if (cnt_r == 6'(chlcd_pkg::NUM_BITS - 1)) state_nxt = chlcd_pkg::ST_SKIP;
      end
      chlcd_pkg::ST_SKIP: begin
        if (!(cnt_r > 6'd1 && top_digit == 4'd0)) state_nxt = chlcd_pkg::ST_GOTO;
      end
      chlcd_pkg::ST_INIT: begin
        if (can_emit && emit_last) state_nxt = chlcd_pkg::ST_IDLE;
      end
      chlcd_pkg::ST_GOTO: begin
        if (can_emit) begin
          state_nxt = emit_last ? chlcd_pkg::ST_IDLE : chlcd_pkg::ST_DATA;
        end
      end
      chlcd_pkg::ST_DATA: begin
        if (can_emit && emit_last) state_nxt = chlcd_pkg::ST_IDLE;
      end
      chlcd_pkg::ST_GHDR: begin
        if (can_emit) state_nxt = chlcd_pkg::ST_GROW;
      end
      chlcd_pkg::ST_GROW: begin
        if (can_emit && cnt_r == 6'(chlcd_pkg::GLYPH_ROWS - 1)) begin
          state_nxt = chlcd_pkg::ST_GOTO;
        end
      end
      default: state_nxt = chlcd_pkg::ST_IDLE;
    endcase
  end

  // bus write formed in the current state
  always_comb begin
    emit      = 1'b0;
    emit_rs   = chlcd_pkg::RS_CMD;
    emit_byte = 8'h00;
    emit_last = 1'b0;
    unique case (state_r)
      chlcd_pkg::ST_INIT: begin
        emit      = can_emit;
        emit_byte = chlcd_pkg::init_byte(cnt_r[1:0]);
        emit_last = (cnt_r == 6'(chlcd_pkg::INIT_WRITES - 1));
      end
      chlcd_pkg::ST_GOTO: begin
        emit      = can_emit;
        emit_byte = {1'b1, row_r, col_r};
        emit_last = (cmd_r == chlcd_pkg::CMD_GOTO);
      end
      chlcd_pkg::ST_DATA: begin
        emit = can_emit;
        if (wrap) begin
          // cursor at end of row 0: move to row 1 first
          emit_byte = chlcd_pkg::WRAP_GOTO_BYTE;
        end else begin
          emit_rs   = chlcd_pkg::RS_DATA;
          emit_last = (cmd_r != chlcd_pkg::CMD_NUMBER) || (cnt_r == 6'd1);
          case (cmd_r)
            chlcd_pkg::CMD_CHAR:   emit_byte = char_r;
            chlcd_pkg::CMD_NUMBER: emit_byte = {chlcd_pkg::ASCII_DIGIT_HI, top_digit};
            default:               emit_byte = {5'b0, gidx_r};
          endcase
        end
      end
      chlcd_pkg::ST_GHDR: begin
        emit      = can_emit;
        emit_byte = {2'b01, gidx_r, 3'b000};
      end
      chlcd_pkg::ST_GROW: begin
        emit      = can_emit;
        emit_rs   = chlcd_pkg::RS_DATA;
        emit_byte = rows_r[7:0];
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // add-3 correction on every decimal digit before each shift
  always_comb begin
    for (int d = 0; d < chlcd_pkg::NUM_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                      : bcd_r[4*d +: 4];
    end
  end

  // datapath next values
  always_comb begin
    cmd_nxt    = cmd_r;
    char_nxt   = char_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    gidx_nxt   = gidx_r;
    rows_nxt   = rows_r;
    num_nxt    = num_r;
    bcd_nxt    = bcd_r;
    cnt_nxt    = cnt_r;
    cursor_nxt = cursor_r;
    case (state_r)
      chlcd_pkg::ST_IDLE: begin
        if (in_take) begin
          cmd_nxt  = in_cmd;
          char_nxt = in_char_code;
          row_nxt  = in_row;
          col_nxt  = in_column;
          gidx_nxt = in_glyph_index[2:0];
          rows_nxt = in_glyph_rows;
          num_nxt  = in_number;
          bcd_nxt  = '0;
          cnt_nxt  = 6'd0;
          if (in_cmd == chlcd_pkg::CMD_INIT) cursor_nxt = 8'd0;
        end
      end
      chlcd_pkg::ST_CONV: begin
        bcd_nxt = {bcd_adj[BCDW-2:0], num_r[31]};
        num_nxt = {num_r[30:0], 1'b0};
        if (cnt_r == 6'(chlcd_pkg::NUM_BITS - 1)) cnt_nxt = 6'(chlcd_pkg::NUM_DIGITS);
        else cnt_nxt = cnt_r + 6'd1;
      end
      chlcd_pkg::ST_SKIP: begin
        // drop a leading zero, keeping at least one digit
        if (cnt_r > 6'd1 && top_digit == 4'd0) begin
          bcd_nxt = {bcd_r[BCDW-5:0], 4'd0};
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      chlcd_pkg::ST_INIT: begin
        if (emit) cnt_nxt = cnt_r + 6'd1;
      end
      chlcd_pkg::ST_GOTO: begin
        if (emit) cursor_nxt = {1'b0, row_r, col_r};
      end
      chlcd_pkg::ST_DATA: begin
        if (emit) begin
          if (wrap) begin
            cursor_nxt = chlcd_pkg::ROW1_BASE;
          end else begin
            cursor_nxt = cursor_r + 8'd1;
            bcd_nxt    = {bcd_r[BCDW-5:0], 4'd0};
            cnt_nxt    = cnt_r - 6'd1;
          end
        end
      end
      chlcd_pkg::ST_GHDR: begin
        if (emit) cnt_nxt = 6'd0;
      end
      chlcd_pkg::ST_GROW: begin
        if (emit) begin
          rows_nxt = {8'h00, rows_r[63:8]};
          cnt_nxt  = cnt_r + 6'd1;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= chlcd_pkg::ST_IDLE;
      cursor_r <= 8'd0;
      cnt_r    <= 6'd0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // request payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    char_r <= char_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    gidx_r <= gidx_nxt;
    rows_r <= rows_nxt;
    num_r  <= num_nxt;
    bcd_r  <= bcd_nxt;
  end

  // output register: loads a write, clears when its transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rs_r   <= emit_rs;
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_bus_byte   = out_byte_r;
  assign out_last       = out_last_r;

endmodule
